FILE: sv/vwbf_pkg.sv
package vwbf_pkg;

  // The store word is fixed at the width of one item.
  localparam int WORD_BITS     = 64;
  localparam int WORD_LOG      = $clog2(WORD_BITS);
  localparam int CAPACITY_BITS = 1024;
  localparam int COUNT_W       = 7;
  localparam int BITS_LEFT_W   = 11;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [63:0]          value;
    logic [COUNT_W-1:0]   bit_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0]            popped_bits;
    logic [BITS_LEFT_W-1:0] bits_left;
    logic                   overflow;
  } out_item_t;

  // Travels with an item from the pointer stage to the extract stage.
  typedef struct packed {
    logic                   swap;
    logic [WORD_LOG-1:0]    offset;
    logic [COUNT_W-1:0]     take;
    logic [BITS_LEFT_W-1:0] bits_left;
    logic                   overflow;
  } pop_meta_t;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [COUNT_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    if (n >= COUNT_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
    end
    return m;
  endfunction

endpackage

FILE: sv/vwbf_ram.sv
module vwbf_ram #(
  parameter int WIDTH = vwbf_pkg::WORD_BITS,
  parameter int DEPTH = vwbf_pkg::CAPACITY_BITS / (2 * vwbf_pkg::WORD_BITS)
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [WIDTH-1:0]                      wmask,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/vwbf_ctrl.sv
module vwbf_ctrl #(
  parameter int CAPACITY_BITS = vwbf_pkg::CAPACITY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  vwbf_pkg::in_item_t  item,
  output logic                item_stall,
  input  logic                s2_ready,
  output logic                fire,
  output vwbf_pkg::pop_meta_t meta,
  output logic                even_we,
  output logic                odd_we,
  output logic [((CAPACITY_BITS / (2 * vwbf_pkg::WORD_BITS) > 1) ?
                 $clog2(CAPACITY_BITS / (2 * vwbf_pkg::WORD_BITS)) : 1)-1:0] even_addr,
  output logic [((CAPACITY_BITS / (2 * vwbf_pkg::WORD_BITS) > 1) ?
                 $clog2(CAPACITY_BITS / (2 * vwbf_pkg::WORD_BITS)) : 1)-1:0] odd_addr,
  output logic [vwbf_pkg::WORD_BITS-1:0] even_wdata,
  output logic [vwbf_pkg::WORD_BITS-1:0] even_wmask,
  output logic [vwbf_pkg::WORD_BITS-1:0] odd_wdata,
  output logic [vwbf_pkg::WORD_BITS-1:0] odd_wmask
);

  localparam int WB         = vwbf_pkg::WORD_BITS;
  localparam int WL         = vwbf_pkg::WORD_LOG;
  localparam int CW         = vwbf_pkg::COUNT_W;
  localparam int BW         = vwbf_pkg::BITS_LEFT_W;
  localparam int PW         = $clog2(CAPACITY_BITS);
  localparam int FW         = $clog2(CAPACITY_BITS + 1);
  localparam int BANK_DEPTH = CAPACITY_BITS / (2 * WB);
  localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic               v1;
  vwbf_pkg::in_item_t in_q;
  logic [PW-1:0]      rp, rp_next;
  logic [FW-1:0]      fill, fill_next;
  logic [CW-1:0]      cnt, take;
  logic               is_push, ovf;
  logic [FW:0]        push_sum, wsum;
  logic [PW:0]        rsum;
  logic [PW-1:0]      wpos, pos;
  logic [ADDR_W-1:0]  a, a_inc;
  logic [WB-1:0]      lm;
  logic [2*WB-1:0]    sh_data, sh_mask;

  assign item_stall = v1 && !s2_ready;
  assign fire       = v1 && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (item_valid && !item_stall) begin
      v1 <= 1'b1;
    end else if (fire) begin
      v1 <= 1'b0;
    end
    if (item_valid && !item_stall) begin
      in_q <= item;
    end
  end

  always_comb begin
    is_push  = (in_q.kind == vwbf_pkg::KIND_PUSH);
    cnt      = (in_q.bit_count > CW'(WB)) ? CW'(WB) : in_q.bit_count;
    push_sum = {1'b0, fill} + (FW + 1)'(cnt);
    ovf      = is_push && (push_sum > (FW + 1)'(CAPACITY_BITS));
    if (is_push) begin
      take = '0;
    end else begin
      take = ((FW)'(cnt) < fill) ? cnt : CW'(fill);
    end

    // Tail position: head plus fill, wrapped once around the ring.
    wsum = {1'b0, fill} + (FW + 1)'(rp);
    if (wsum >= (FW + 1)'(CAPACITY_BITS)) begin
      wpos = PW'(wsum - (FW + 1)'(CAPACITY_BITS));
    end else begin
      wpos = PW'(wsum);
    end
    pos = is_push ? wpos : rp;

    rsum = (PW + 1)'(rp) + (PW + 1)'(take);
    if (rsum >= (PW + 1)'(CAPACITY_BITS)) begin
      rp_next = PW'(rsum - (PW + 1)'(CAPACITY_BITS));
    end else begin
      rp_next = PW'(rsum);
    end

    if (is_push) begin
      fill_next = ovf ? fill : FW'(push_sum);
    end else begin
      fill_next = fill - FW'(take);
    end

    // Even words live in one bank, odd words in the other, so the two
    // words an item touches always sit in different banks.
    a = ADDR_W'(pos >> (WL + 1));
    if (a == ADDR_W'(BANK_DEPTH - 1)) begin
      a_inc = '0;
    end else begin
      a_inc = a + ADDR_W'(1);
    end
    even_addr = pos[WL] ? a_inc : a;
    odd_addr  = a;

    lm      = vwbf_pkg::low_mask(cnt);
    sh_data = {{WB{1'b0}}, in_q.value & lm} << pos[WL-1:0];
    sh_mask = {{WB{1'b0}}, lm} << pos[WL-1:0];
    even_wdata = pos[WL] ? sh_data[2*WB-1:WB] : sh_data[WB-1:0];
    even_wmask = pos[WL] ? sh_mask[2*WB-1:WB] : sh_mask[WB-1:0];
    odd_wdata  = pos[WL] ? sh_data[WB-1:0] : sh_data[2*WB-1:WB];
    odd_wmask  = pos[WL] ? sh_mask[WB-1:0] : sh_mask[2*WB-1:WB];
    even_we    = fire && is_push && !ovf;
    odd_we     = fire && is_push && !ovf;

    meta.swap      = pos[WL];
    meta.offset    = pos[WL-1:0];
    meta.take      = take;
    meta.bits_left = BW'(fill_next);
    meta.overflow  = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp   <= '0;
      fill <= '0;
    end else if (fire) begin
      rp   <= rp_next;
      fill <= fill_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(CAPACITY_BITS))
    else $error("fill count beyond capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    (PW + 1)'(rp) < (PW + 1)'(CAPACITY_BITS))
    else $error("read position outside the ring");

  a_push_fill: assert property (@(posedge clk) disable iff (rst)
    fire && is_push && !ovf |=> fill == $past(fill) + FW'($past(cnt)))
    else $error("accepted push did not grow the fill by its count");

  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    fire && !is_push |=> fill == $past(fill) - FW'($past(take)))
    else $error("pop did not shrink the fill by the bits it took");

endmodule

FILE: sv/vwbf_align.sv
module vwbf_align (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  vwbf_pkg::pop_meta_t            meta,
  input  logic [vwbf_pkg::WORD_BITS-1:0] even_q,
  input  logic [vwbf_pkg::WORD_BITS-1:0] odd_q,
  output logic                           s2_ready,
  output logic                           result_valid,
  input  logic                           result_stall,
  output vwbf_pkg::out_item_t            result
);

  localparam int WB = vwbf_pkg::WORD_BITS;

  logic                v2;
  vwbf_pkg::pop_meta_t meta2;
  logic                ready3, load3;
  logic [WB-1:0]       lo, hi;
  logic [2*WB-1:0]     both;
  vwbf_pkg::out_item_t res_next;

  assign ready3   = !result_valid || !result_stall;
  assign load3    = v2 && ready3;
  assign s2_ready = !v2 || ready3;

  // The bank data is registered inside the RAMs on the same edge as meta2.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (fire) begin
      v2 <= 1'b1;
    end else if (load3) begin
      v2 <= 1'b0;
    end
    if (fire) begin
      meta2 <= meta;
    end
  end

  always_comb begin
    lo   = meta2.swap ? odd_q : even_q;
    hi   = meta2.swap ? even_q : odd_q;
    both = {hi, lo} >> meta2.offset;
    res_next.popped_bits = both[WB-1:0] & vwbf_pkg::low_mask(meta2.take);
    res_next.bits_left   = meta2.bits_left;
    res_next.overflow    = meta2.overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load3) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (load3) begin
      result <= res_next;
    end
  end

  a_no_pop_on_overflow: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overflow |-> result.popped_bits == '0)
    else $error("refused push returned popped bits");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    v2 && !ready3 |=> v2 && $stable(meta2))
    else $error("extract stage lost its beat under stall");

  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    fire |-> s2_ready)
    else $error("pointer stage fired into a full extract stage");

endmodule

FILE: sv/variable_width_bit_fifo.sv
// Bit-level FIFO of CAPACITY_BITS bits. A push beat appends the low bit_count bits of value
// (counts above 64 act as 64); a push that would exceed capacity is refused and flagged by
// overflow. A pop beat removes up to bit_count of the oldest bits and returns them in
// popped_bits, oldest bit at bit 0, zero-extended when fewer bits are pending. Every beat
// gives one result beat with the fill after it in bits_left. One item is taken per clock
// while item_stall is low, and each passes the input register, then the registered read
// of the two 64-bit store banks (even and odd words), then the result register.
// CAPACITY_BITS must be a multiple of 128.
module variable_width_bit_fifo #(
  parameter int CAPACITY_BITS = vwbf_pkg::CAPACITY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  vwbf_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output vwbf_pkg::out_item_t result
);

  localparam int WB         = vwbf_pkg::WORD_BITS;
  localparam int BANK_DEPTH = CAPACITY_BITS / (2 * WB);
  localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic                s2_ready, fire;
  vwbf_pkg::pop_meta_t meta;
  logic                even_we, odd_we;
  logic [ADDR_W-1:0]   even_addr, odd_addr;
  logic [WB-1:0]       even_wdata, even_wmask, odd_wdata, odd_wmask;
  logic [WB-1:0]       even_q, odd_q;

  vwbf_ctrl #(
    .CAPACITY_BITS(CAPACITY_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .s2_ready   (s2_ready),
    .fire       (fire),
    .meta       (meta),
    .even_we    (even_we),
    .odd_we     (odd_we),
    .even_addr  (even_addr),
    .odd_addr   (odd_addr),
    .even_wdata (even_wdata),
    .even_wmask (even_wmask),
    .odd_wdata  (odd_wdata),
    .odd_wmask  (odd_wmask)
  );

  vwbf_ram #(
    .WIDTH(WB),
    .DEPTH(BANK_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_addr),
    .wdata (even_wdata),
    .wmask (even_wmask),
    .re    (fire),
    .raddr (even_addr),
    .rdata (even_q)
  );

  vwbf_ram #(
    .WIDTH(WB),
    .DEPTH(BANK_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_addr),
    .wdata (odd_wdata),
    .wmask (odd_wmask),
    .re    (fire),
    .raddr (odd_addr),
    .rdata (odd_q)
  );

  vwbf_align u_align (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .meta         (meta),
    .even_q       (even_q),
    .odd_q        (odd_q),
    .s2_ready     (s2_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: dv/tb_variable_width_bit_fifo.sv
module tb_variable_width_bit_fifo;

  localparam int IDLE_PCT      = 36;
  localparam int RANDOM_ITEMS  = 1520;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 250;
  localparam int STEADY_FROM   = 600;
  localparam int STEADY_TO     = 850;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CAPACITY_BITS = vwbf_pkg::CAPACITY_BITS;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  vwbf_pkg::in_item_t  item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  vwbf_pkg::out_item_t result;

  variable_width_bit_fifo uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always #1 clk = ~clk;

  vwbf_pkg::in_item_t  pending_items[$];
  vwbf_pkg::out_item_t expected_results[$];

  // Shadow of the queue contents: a ring of bits with its head and fill.
  bit [CAPACITY_BITS-1:0] shadow_bits;
  int unsigned shadow_head = 0;
  int unsigned shadow_fill = 0;

  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned push_count    = 0;
  int unsigned pop_count     = 0;
  int unsigned refused_count = 0;
  int unsigned short_pops    = 0;
  int unsigned full_hits     = 0;
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  bit          send_gap;

  // Fill as the stimulus generator sees it, used only to steer the mix.
  int unsigned plan_fill = 0;

  function automatic vwbf_pkg::out_item_t fifo_apply(input vwbf_pkg::in_item_t it);
    vwbf_pkg::out_item_t r;
    int unsigned         n;
    int unsigned         wpos;
    r = '0;
    n = (it.bit_count > 7'd64) ? 64 : it.bit_count;
    if (it.kind == vwbf_pkg::KIND_PUSH) begin
      push_count++;
      if (shadow_fill + n > CAPACITY_BITS) begin
        r.overflow = 1'b1;
        refused_count++;
      end else begin
        wpos = shadow_head + shadow_fill;
        for (int i = 0; i < n; i++) shadow_bits[(wpos + i) % CAPACITY_BITS] = it.value[i];
        shadow_fill += n;
        if (shadow_fill == CAPACITY_BITS) full_hits++;
      end
    end else begin
      pop_count++;
      if (n > shadow_fill) begin
        n = shadow_fill;
        short_pops++;
      end
      for (int i = 0; i < n; i++)
        r.popped_bits[i] = shadow_bits[(shadow_head + i) % CAPACITY_BITS];
      shadow_head = (shadow_head + n) % CAPACITY_BITS;
      shadow_fill -= n;
    end
    r.bits_left = vwbf_pkg::BITS_LEFT_W'(shadow_fill);
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_item(input vwbf_pkg::kind_t k, input logic [63:0] v,
                            input int unsigned cnt);
    vwbf_pkg::in_item_t it;
    int unsigned        n;
    it.kind      = k;
    it.value     = v;
    it.bit_count = vwbf_pkg::COUNT_W'(cnt);
    pending_items.push_back(it);
    n = (cnt > 64) ? 64 : cnt;
    if (k == vwbf_pkg::KIND_PUSH) begin
      if (plan_fill + n <= CAPACITY_BITS) plan_fill += n;
    end else begin
      plan_fill -= (n > plan_fill) ? plan_fill : n;
    end
  endtask

  // Picks a count: zero, oversized, full word, one aimed at the fill edge, or ordinary.
  function automatic int unsigned pick_count(input int unsigned edge_cnt);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return 0;
    if (r < 15) return $urandom_range(127, 65);
    if (r < 30) return 64;
    if (r < 40) return (edge_cnt > 127) ? 127 : edge_cnt;
    return $urandom_range(63, 1);
  endfunction

  // Sender: holds a stalled beat, otherwise takes the next pending item or idles.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_results.push_back(fifo_apply(item));
        items_sent++;
      end
      if (!item_valid || !item_stall) begin
        send_gap = (items_sent >= STEADY_FROM && items_sent < STEADY_TO) ? 1'b0 :
                   ($urandom_range(99) < IDLE_PCT);
        if (pending_items.size() > 0 && !send_gap) begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and decides the stall for the next cycle.
  always @(posedge clk) begin
    vwbf_pkg::out_item_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with no expected result: %h", result);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.popped_bits !== want.popped_bits) begin
            $error("popped_bits: expected %h, got %h", want.popped_bits, result.popped_bits);
            error_count++;
          end
          if (result.bits_left !== want.bits_left) begin
            $error("bits_left: expected %0d, got %0d", want.bits_left, result.bits_left);
            error_count++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, result.overflow);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        // Long hold-off so the pipeline backs up and the input side stalls.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else if (results_seen >= STEADY_FROM && results_seen < STEADY_TO) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** variable_width_bit_fifo: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned left_in_mode;
    int unsigned push_pct;

    // Directed part: empty pops, zero and oversized counts, a fill to capacity with a
    // refused push, an exact fill, and a wrap of the ring.
    queue_item(vwbf_pkg::KIND_POP, '1, 0);
    queue_item(vwbf_pkg::KIND_POP, '0, 64);
    queue_item(vwbf_pkg::KIND_PUSH, '1, 0);
    queue_item(vwbf_pkg::KIND_PUSH, '1, 1);
    queue_item(vwbf_pkg::KIND_PUSH, rand64(), 127);
    queue_item(vwbf_pkg::KIND_PUSH, 64'h0123_4567_89ab_cdef, 64);
    queue_item(vwbf_pkg::KIND_POP, rand64(), 1);
    queue_item(vwbf_pkg::KIND_POP, '1, 127);
    queue_item(vwbf_pkg::KIND_POP, '0, 0);
    queue_item(vwbf_pkg::KIND_POP, '0, 100);
    queue_item(vwbf_pkg::KIND_PUSH, '1, 63);
    repeat (15) queue_item(vwbf_pkg::KIND_PUSH, rand64(), 64);
    queue_item(vwbf_pkg::KIND_PUSH, '1, 2);
    queue_item(vwbf_pkg::KIND_PUSH, '1, 1);
    queue_item(vwbf_pkg::KIND_PUSH, '1, 0);
    queue_item(vwbf_pkg::KIND_POP, '0, 65);
    queue_item(vwbf_pkg::KIND_PUSH, '0, 64);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The stimulus waits here until every directed result has come back.
    do @(negedge clk);
    while (pending_items.size() > 0 || item_valid || expected_results.size() > 0);

    // Random part in phases that lean toward filling, draining or neither.
    left_in_mode = 0;
    push_pct     = 50;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (left_in_mode == 0) begin
        mode         = $urandom_range(2);
        left_in_mode = $urandom_range(80, 20);
        push_pct     = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      end
      left_in_mode--;
      if ($urandom_range(99) < push_pct)
        queue_item(vwbf_pkg::KIND_PUSH, rand64(),
                   pick_count(CAPACITY_BITS - plan_fill + $urandom_range(2)));
      else
        queue_item(vwbf_pkg::KIND_POP, rand64(), pick_count(plan_fill + $urandom_range(1)));
    end

    do @(negedge clk);
    while (pending_items.size() > 0 || item_valid || expected_results.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_results.size() > 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    $display("Run covered %0d pushes (%0d refused, %0d reaching capacity) and %0d pops",
             push_count, refused_count, full_hits, pop_count);
    $display("(%0d from a short queue); %0d result beats checked, %0d mismatches.",
             short_pops, results_seen, error_count);
    if (error_count == 0) begin
      $display("** variable_width_bit_fifo: PASSED **");
    end else begin
      $display("** variable_width_bit_fifo: FAILED **");
    end
    $finish;
  end

endmodule
